/* rtl/jfoe_pkg.sv */
package jfoe_pkg;

    localparam int MAX_CODE    = 65536;
    localparam int MAX_REQUEST = 65536;
    localparam int KEY_CAP     = 32;

    localparam int KEY_W  = $clog2(KEY_CAP);
    localparam int CODE_W = $clog2(MAX_CODE);
    localparam int REQ_W  = $clog2(MAX_REQUEST + 2);

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic [2:0] MATCH_DONE = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd5;
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_D   = 8'h64;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_O   = 8'h6F;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_INVALID       = 3'd1,
        ST_MISSING       = 3'd2,
        ST_NOT_STRING    = 3'd3,
        ST_TOO_LARGE     = 3'd4,
        ST_REQ_TOO_LARGE = 3'd5,
        ST_NONE          = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        RK_CHAR    = 2'd0,
        RK_RESTART = 2'd1,
        RK_FINAL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SB_KEY  = 2'd0,
        SB_CODE = 2'd1,
        SB_SKIP = 2'd2
    } str_base_t;

    typedef enum logic [4:0] {
        P_BEFORE_OPEN  = 5'd0,
        P_AFTER_OPEN   = 5'd1,
        P_KEY_START    = 5'd2,
        P_KEY          = 5'd3,
        P_KEY_ESC      = 5'd4,
        P_KEY_HEX      = 5'd5,
        P_COLON        = 5'd6,
        P_VALUE_START  = 5'd7,
        P_CODE         = 5'd8,
        P_CODE_ESC     = 5'd9,
        P_CODE_HEX     = 5'd10,
        P_SKIP         = 5'd11,
        P_SKIP_ESC     = 5'd12,
        P_SKIP_HEX     = 5'd13,
        P_NUM_MINUS    = 5'd14,
        P_NUM_ZERO     = 5'd15,
        P_NUM_INT      = 5'd16,
        P_NUM_DOT      = 5'd17,
        P_NUM_FRAC     = 5'd18,
        P_NUM_EXP      = 5'd19,
        P_NUM_EXP_SIGN = 5'd20,
        P_NUM_EXP_DIG  = 5'd21,
        P_LIT_TRUE     = 5'd22,
        P_LIT_FALSE    = 5'd23,
        P_LIT_NULL     = 5'd24,
        P_AFTER_VALUE  = 5'd25,
        P_AFTER_CLOSE  = 5'd26
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [2:0]          kmp;
        logic [KEY_W-1:0]    kcc;
        logic [2:0]          ehc;
        logic [2:0]          lit;
        logic                found;
        logic [CODE_W-1:0]   ccc;
        logic [REQ_W-1:0]    req;
        status_t             lat;
        logic                ended;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: P_BEFORE_OPEN,
        kmp:   3'd0,
        kcc:   '0,
        ehc:   3'd0,
        lit:   3'd0,
        found: 1'b0,
        ccc:   '0,
        req:   '0,
        lat:   ST_NONE,
        ended: 1'b0
    };

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic [2:0]  st;
        logic [15:0] len;
        logic        last_run;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= CH_LO_A) && (c <= CH_LO_F))
            || ((c >= CH_UP_A) && (c <= CH_UP_F));
    endfunction

    function automatic logic is_code_phase(input phase_t p);
        return (p == P_CODE) || (p == P_CODE_ESC) || (p == P_CODE_HEX);
    endfunction

    function automatic logic [7:0] code_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_LO_C;
            2'd1:    ch = CH_LO_O;
            2'd2:    ch = CH_LO_D;
            default: ch = CH_LO_E;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        logic [2:0] n;
        case (w)
            2'd1:    n = 3'd5;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        case (w)
            2'd0:
            begin
                case (i)
                    3'd0:    ch = CH_LO_T;
                    3'd1:    ch = CH_LO_R;
                    3'd2:    ch = CH_LO_U;
                    3'd3:    ch = CH_LO_E;
                    default: ch = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (i)
                    3'd0:    ch = CH_LO_F;
                    3'd1:    ch = CH_LO_A;
                    3'd2:    ch = CH_LO_L;
                    3'd3:    ch = CH_LO_S;
                    3'd4:    ch = CH_LO_E;
                    default: ch = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (i)
                    3'd0:    ch = CH_LO_N;
                    3'd1:    ch = CH_LO_U;
                    3'd2:    ch = CH_LO_L;
                    3'd3:    ch = CH_LO_L;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/jfoe_in_if.sv */
interface jfoe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/jfoe_out_if.sv */
interface jfoe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  char_byte;
    logic [2:0]  status;
    logic [15:0] value_length;
    logic        last_of_run;

    modport source (output valid, output result_kind, output char_byte, output status,
                    output value_length, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input char_byte, input status,
                    input value_length, input last_of_run, output ready);
endinterface

/* rtl/json_flat_object_field_extractor_top.sv */
// Parses one JSON request byte per clock while the queue has room and streams out the
// decoded characters of every value whose key begins with "code", each value opened by a
// restart word; the word for the byte marked last also yields the final status and code
// length, after which the parser is back in its reset state for the next request. A byte
// is parsed in the cycle it is accepted and its result words are written into the queue
// as it is taken. Results pass through a four-word queue that drains one word per cycle;
// input is taken whenever at least two queue entries are free, so the sustained rate is
// one byte per cycle as long as the result side keeps up with one word per cycle.
module json_flat_object_field_extractor_top (
    input logic        clk,
    input logic        rst_n,
    jfoe_in_if.sink    in_word,
    jfoe_out_if.source out_word
);

    jfoe_pkg::state_t state_reg;
    jfoe_pkg::state_t state_next;
    jfoe_pkg::state_t step_nxt;
    jfoe_pkg::res_t   res0;
    jfoe_pkg::res_t   res1;
    jfoe_pkg::res_t   q_data;
    logic [1:0]       res_cnt;
    logic [1:0]       wr_cnt;
    logic             accept;
    logic             q_valid;
    logic             q_room;

    jfoe_step u_step (
        .cur       (state_reg),
        .data_byte (in_word.data_byte),
        .last_byte (in_word.last_byte),
        .nxt       (step_nxt),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    jfoe_res_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr0      (res0),
        .wr1      (res1),
        .rd_en    (q_valid && out_word.ready),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .room     (q_room)
    );

    assign in_word.ready = q_room;
    assign accept        = in_word.valid && q_room;
    assign wr_cnt        = accept ? res_cnt : 2'd0;
    assign state_next    = accept ? step_nxt : state_reg;

    assign out_word.valid        = q_valid;
    assign out_word.result_kind  = q_data.kind;
    assign out_word.char_byte    = q_data.ch;
    assign out_word.status       = q_data.st;
    assign out_word.value_length = q_data.len;
    assign out_word.last_of_run  = q_data.last_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jfoe_pkg::STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/jfoe_step.sv */
module jfoe_step (
    input  jfoe_pkg::state_t cur,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output jfoe_pkg::state_t nxt,
    output logic [1:0]       res_cnt,
    output jfoe_pkg::res_t   res0,
    output jfoe_pkg::res_t   res1
);

    jfoe_pkg::state_t    ps;
    jfoe_pkg::state_t    s1;
    jfoe_pkg::state_t    s2;
    logic [jfoe_pkg::REQ_W-1:0] req_inc;
    logic                in_range;
    logic                do_zero;
    logic                do_parse;
    logic                fail_en;
    jfoe_pkg::status_t   fail_st;
    logic                emit_en;
    jfoe_pkg::kind_t     emit_kind;
    logic [7:0]          emit_ch;
    logic                str_en;
    jfoe_pkg::str_base_t str_base;
    logic [1:0]          str_sub;
    logic                sc_en;
    logic [7:0]          sc_ch;
    jfoe_pkg::phase_t    ph_main;
    jfoe_pkg::phase_t    ph_esc;
    jfoe_pkg::phase_t    ph_hex;
    jfoe_pkg::phase_t    av_phase;
    logic                av_fail;
    logic                is_e;
    logic [1:0]          lw;
    logic                end_en;
    logic                over;
    jfoe_pkg::res_t      final_res;
    jfoe_pkg::res_t      emit_res;

    assign req_inc  = (cur.req <= jfoe_pkg::REQ_W'(jfoe_pkg::MAX_REQUEST))
                    ? cur.req + jfoe_pkg::REQ_W'(1) : cur.req;
    assign in_range = (req_inc <= jfoe_pkg::REQ_W'(jfoe_pkg::MAX_REQUEST)) && !cur.ended;
    assign do_zero  = in_range && (data_byte == 8'h00);
    assign do_parse = in_range && (data_byte != 8'h00) && (cur.lat == jfoe_pkg::ST_NONE);
    assign is_e     = (data_byte == jfoe_pkg::CH_LO_E) || (data_byte == jfoe_pkg::CH_UP_E);

    // what a byte does once a value has closed
    always_comb
    begin
        av_phase = jfoe_pkg::P_AFTER_VALUE;
        av_fail  = 1'b0;
        if (jfoe_pkg::is_ws(data_byte))
        begin
            av_phase = jfoe_pkg::P_AFTER_VALUE;
        end
        else if (data_byte == jfoe_pkg::CH_RBRACE)
        begin
            av_phase = jfoe_pkg::P_AFTER_CLOSE;
        end
        else if (data_byte == jfoe_pkg::CH_COMMA)
        begin
            av_phase = jfoe_pkg::P_KEY_START;
        end
        else
        begin
            av_fail = 1'b1;
        end
    end

    always_comb
    begin
        case (cur.phase)
            jfoe_pkg::P_LIT_FALSE: lw = 2'd1;
            jfoe_pkg::P_LIT_NULL:  lw = 2'd2;
            default:               lw = 2'd0;
        endcase
    end

    always_comb
    begin
        ps        = cur;
        fail_en   = 1'b0;
        fail_st   = jfoe_pkg::ST_INVALID;
        emit_en   = 1'b0;
        emit_kind = jfoe_pkg::RK_CHAR;
        emit_ch   = 8'h00;
        str_en    = 1'b0;
        str_base  = jfoe_pkg::SB_SKIP;
        str_sub   = 2'd0;
        sc_en     = 1'b0;
        sc_ch     = 8'h00;
        ph_main   = jfoe_pkg::P_SKIP;
        ph_esc    = jfoe_pkg::P_SKIP_ESC;
        ph_hex    = jfoe_pkg::P_SKIP_HEX;

        if (do_parse)
        begin
            case (cur.phase)
                jfoe_pkg::P_BEFORE_OPEN:
                begin
                    if (data_byte == jfoe_pkg::CH_LBRACE)
                    begin
                        ps.phase = jfoe_pkg::P_AFTER_OPEN;
                    end
                    else if (!jfoe_pkg::is_ws(data_byte))
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_AFTER_OPEN, jfoe_pkg::P_KEY_START:
                begin
                    if (!jfoe_pkg::is_ws(data_byte))
                    begin
                        if (data_byte == jfoe_pkg::CH_QUOTE)
                        begin
                            ps.kmp   = 3'd0;
                            ps.kcc   = '0;
                            ps.phase = jfoe_pkg::P_KEY;
                        end
                        else if ((data_byte == jfoe_pkg::CH_RBRACE)
                                 && (cur.phase == jfoe_pkg::P_AFTER_OPEN))
                        begin
                            ps.phase = jfoe_pkg::P_AFTER_CLOSE;
                        end
                        else
                        begin
                            fail_en = 1'b1;
                        end
                    end
                end
                jfoe_pkg::P_KEY:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_KEY; str_sub = 2'd0;
                end
                jfoe_pkg::P_KEY_ESC:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_KEY; str_sub = 2'd1;
                end
                jfoe_pkg::P_KEY_HEX:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_KEY; str_sub = 2'd2;
                end
                jfoe_pkg::P_CODE:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_CODE; str_sub = 2'd0;
                end
                jfoe_pkg::P_CODE_ESC:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_CODE; str_sub = 2'd1;
                end
                jfoe_pkg::P_CODE_HEX:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_CODE; str_sub = 2'd2;
                end
                jfoe_pkg::P_SKIP:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_SKIP; str_sub = 2'd0;
                end
                jfoe_pkg::P_SKIP_ESC:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_SKIP; str_sub = 2'd1;
                end
                jfoe_pkg::P_SKIP_HEX:
                begin
                    str_en = 1'b1; str_base = jfoe_pkg::SB_SKIP; str_sub = 2'd2;
                end
                jfoe_pkg::P_COLON:
                begin
                    if (data_byte == jfoe_pkg::CH_COLON)
                    begin
                        ps.phase = jfoe_pkg::P_VALUE_START;
                    end
                    else if (!jfoe_pkg::is_ws(data_byte))
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_VALUE_START:
                begin
                    if (jfoe_pkg::is_ws(data_byte))
                    begin
                        ps.phase = cur.phase;
                    end
                    else if (cur.kmp == jfoe_pkg::MATCH_DONE)
                    begin
                        if (data_byte == jfoe_pkg::CH_QUOTE)
                        begin
                            ps.ccc    = '0;
                            ps.phase  = jfoe_pkg::P_CODE;
                            emit_en   = 1'b1;
                            emit_kind = jfoe_pkg::RK_RESTART;
                        end
                        else if ((data_byte == jfoe_pkg::CH_COMMA)
                                 || (data_byte == jfoe_pkg::CH_RBRACE))
                        begin
                            fail_en = 1'b1;
                        end
                        else
                        begin
                            fail_en = 1'b1;
                            fail_st = jfoe_pkg::ST_NOT_STRING;
                        end
                    end
                    else if (data_byte == jfoe_pkg::CH_QUOTE)
                    begin
                        ps.phase = jfoe_pkg::P_SKIP;
                    end
                    else if (data_byte == jfoe_pkg::CH_MINUS)
                    begin
                        ps.phase = jfoe_pkg::P_NUM_MINUS;
                    end
                    else if (data_byte == jfoe_pkg::CH_ZERO)
                    begin
                        ps.phase = jfoe_pkg::P_NUM_ZERO;
                    end
                    else if (jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = jfoe_pkg::P_NUM_INT;
                    end
                    else if (data_byte == jfoe_pkg::CH_LO_T)
                    begin
                        ps.phase = jfoe_pkg::P_LIT_TRUE;
                        ps.lit   = 3'd1;
                    end
                    else if (data_byte == jfoe_pkg::CH_LO_F)
                    begin
                        ps.phase = jfoe_pkg::P_LIT_FALSE;
                        ps.lit   = 3'd1;
                    end
                    else if (data_byte == jfoe_pkg::CH_LO_N)
                    begin
                        ps.phase = jfoe_pkg::P_LIT_NULL;
                        ps.lit   = 3'd1;
                    end
                    else
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_NUM_MINUS:
                begin
                    if (data_byte == jfoe_pkg::CH_ZERO)
                    begin
                        ps.phase = jfoe_pkg::P_NUM_ZERO;
                    end
                    else if (jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = jfoe_pkg::P_NUM_INT;
                    end
                    else
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_NUM_ZERO, jfoe_pkg::P_NUM_INT:
                begin
                    if ((cur.phase == jfoe_pkg::P_NUM_INT) && jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = cur.phase;
                    end
                    else if (data_byte == jfoe_pkg::CH_DOT)
                    begin
                        ps.phase = jfoe_pkg::P_NUM_DOT;
                    end
                    else if (is_e)
                    begin
                        ps.phase = jfoe_pkg::P_NUM_EXP;
                    end
                    else
                    begin
                        ps.phase = av_phase;
                        fail_en  = av_fail;
                    end
                end
                jfoe_pkg::P_NUM_DOT:
                begin
                    if (jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = jfoe_pkg::P_NUM_FRAC;
                    end
                    else
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_NUM_FRAC:
                begin
                    if (jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = cur.phase;
                    end
                    else if (is_e)
                    begin
                        ps.phase = jfoe_pkg::P_NUM_EXP;
                    end
                    else
                    begin
                        ps.phase = av_phase;
                        fail_en  = av_fail;
                    end
                end
                jfoe_pkg::P_NUM_EXP:
                begin
                    if ((data_byte == jfoe_pkg::CH_PLUS) || (data_byte == jfoe_pkg::CH_MINUS))
                    begin
                        ps.phase = jfoe_pkg::P_NUM_EXP_SIGN;
                    end
                    else if (jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = jfoe_pkg::P_NUM_EXP_DIG;
                    end
                    else
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_NUM_EXP_SIGN:
                begin
                    if (jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = jfoe_pkg::P_NUM_EXP_DIG;
                    end
                    else
                    begin
                        fail_en = 1'b1;
                    end
                end
                jfoe_pkg::P_NUM_EXP_DIG:
                begin
                    if (!jfoe_pkg::is_dig(data_byte))
                    begin
                        ps.phase = av_phase;
                        fail_en  = av_fail;
                    end
                end
                jfoe_pkg::P_LIT_TRUE, jfoe_pkg::P_LIT_FALSE, jfoe_pkg::P_LIT_NULL:
                begin
                    if ((cur.lit >= jfoe_pkg::lit_len(lw))
                        || (data_byte != jfoe_pkg::lit_char(lw, cur.lit)))
                    begin
                        fail_en = 1'b1;
                    end
                    else if ((cur.lit + 3'd1) >= jfoe_pkg::lit_len(lw))
                    begin
                        ps.lit   = 3'd0;
                        ps.phase = jfoe_pkg::P_AFTER_VALUE;
                    end
                    else
                    begin
                        ps.lit = cur.lit + 3'd1;
                    end
                end
                jfoe_pkg::P_AFTER_VALUE:
                begin
                    ps.phase = av_phase;
                    fail_en  = av_fail;
                end
                jfoe_pkg::P_AFTER_CLOSE:
                begin
                    if (!jfoe_pkg::is_ws(data_byte))
                    begin
                        fail_en = 1'b1;
                    end
                end
                default:
                begin
                    fail_en = 1'b1;
                end
            endcase
        end

        case (str_base)
            jfoe_pkg::SB_KEY:
            begin
                ph_main = jfoe_pkg::P_KEY;
                ph_esc  = jfoe_pkg::P_KEY_ESC;
                ph_hex  = jfoe_pkg::P_KEY_HEX;
            end
            jfoe_pkg::SB_CODE:
            begin
                ph_main = jfoe_pkg::P_CODE;
                ph_esc  = jfoe_pkg::P_CODE_ESC;
                ph_hex  = jfoe_pkg::P_CODE_HEX;
            end
            default:
            begin
                ph_main = jfoe_pkg::P_SKIP;
                ph_esc  = jfoe_pkg::P_SKIP_ESC;
                ph_hex  = jfoe_pkg::P_SKIP_HEX;
            end
        endcase

        // string body, escape and hex digits
        if (str_en)
        begin
            case (str_sub)
                2'd0:
                begin
                    if (data_byte == jfoe_pkg::CH_QUOTE)
                    begin
                        if (str_base == jfoe_pkg::SB_KEY)
                        begin
                            ps.phase = jfoe_pkg::P_COLON;
                        end
                        else
                        begin
                            if (str_base == jfoe_pkg::SB_CODE)
                            begin
                                ps.found = 1'b1;
                            end
                            ps.phase = jfoe_pkg::P_AFTER_VALUE;
                        end
                    end
                    else if (data_byte < jfoe_pkg::CH_SPACE)
                    begin
                        fail_en = 1'b1;
                    end
                    else if (data_byte == jfoe_pkg::CH_BSLASH)
                    begin
                        ps.phase = ph_esc;
                    end
                    else
                    begin
                        sc_en = 1'b1;
                        sc_ch = data_byte;
                    end
                end
                2'd1:
                begin
                    case (data_byte)
                        jfoe_pkg::CH_QUOTE, jfoe_pkg::CH_BSLASH, jfoe_pkg::CH_SLASH:
                        begin
                            sc_en = 1'b1; sc_ch = data_byte;
                        end
                        jfoe_pkg::CH_LO_B:
                        begin
                            sc_en = 1'b1; sc_ch = jfoe_pkg::CH_BS;
                        end
                        jfoe_pkg::CH_LO_F:
                        begin
                            sc_en = 1'b1; sc_ch = jfoe_pkg::CH_FF;
                        end
                        jfoe_pkg::CH_LO_N:
                        begin
                            sc_en = 1'b1; sc_ch = jfoe_pkg::CH_LF;
                        end
                        jfoe_pkg::CH_LO_R:
                        begin
                            sc_en = 1'b1; sc_ch = jfoe_pkg::CH_CR;
                        end
                        jfoe_pkg::CH_LO_T:
                        begin
                            sc_en = 1'b1; sc_ch = jfoe_pkg::CH_TAB;
                        end
                        jfoe_pkg::CH_LO_U:
                        begin
                            ps.ehc   = 3'd0;
                            ps.phase = ph_hex;
                        end
                        default:
                        begin
                            fail_en = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    if (!jfoe_pkg::is_hex(data_byte))
                    begin
                        fail_en = 1'b1;
                    end
                    else if ((cur.ehc + 3'd1) >= jfoe_pkg::HEX_DIGITS)
                    begin
                        ps.ehc = 3'd0;
                        sc_en  = 1'b1;
                        sc_ch  = jfoe_pkg::CH_QMARK;
                    end
                    else
                    begin
                        ps.ehc = cur.ehc + 3'd1;
                    end
                end
            endcase
        end

        // one decoded string character
        if (sc_en)
        begin
            case (str_base)
                jfoe_pkg::SB_KEY:
                begin
                    if (cur.kcc >= jfoe_pkg::KEY_W'(jfoe_pkg::KEY_CAP - 1))
                    begin
                        fail_en = 1'b1;
                        fail_st = jfoe_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        ps.kcc = cur.kcc + jfoe_pkg::KEY_W'(1);
                        if (cur.kmp < jfoe_pkg::MATCH_DONE)
                        begin
                            ps.kmp = (sc_ch == jfoe_pkg::code_char(cur.kmp[1:0]))
                                   ? cur.kmp + 3'd1 : jfoe_pkg::MATCH_FAIL;
                        end
                        ps.phase = ph_main;
                    end
                end
                jfoe_pkg::SB_CODE:
                begin
                    if (cur.ccc >= jfoe_pkg::CODE_W'(jfoe_pkg::MAX_CODE - 1))
                    begin
                        fail_en = 1'b1;
                        fail_st = jfoe_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        ps.ccc    = cur.ccc + jfoe_pkg::CODE_W'(1);
                        emit_en   = 1'b1;
                        emit_kind = jfoe_pkg::RK_CHAR;
                        emit_ch   = sc_ch;
                        ps.phase  = ph_main;
                    end
                end
                default:
                begin
                    ps.phase = ph_main;
                end
            endcase
        end
    end

    // latch errors, text end and final status
    always_comb
    begin
        s1     = ps;
        s1.req = req_inc;
        if (fail_en)
        begin
            s1.lat = fail_st;
            if (jfoe_pkg::is_code_phase(cur.phase))
            begin
                s1.ccc = '0;
            end
        end
        if (do_zero)
        begin
            s1.ended = 1'b1;
        end

        end_en = (do_zero && (cur.lat == jfoe_pkg::ST_NONE))
               || (last_byte && !s1.ended && (s1.lat == jfoe_pkg::ST_NONE));

        s2 = s1;
        if (end_en)
        begin
            if (s1.phase == jfoe_pkg::P_AFTER_CLOSE)
            begin
                s2.lat = s1.found ? jfoe_pkg::ST_OK : jfoe_pkg::ST_MISSING;
            end
            else
            begin
                s2.lat = jfoe_pkg::ST_INVALID;
            end
            if (jfoe_pkg::is_code_phase(s1.phase))
            begin
                s2.ccc = '0;
            end
        end
    end

    assign over = req_inc > jfoe_pkg::REQ_W'(jfoe_pkg::MAX_REQUEST);
    assign nxt  = last_byte ? jfoe_pkg::STATE_RESET : s2;

    always_comb
    begin
        final_res.kind     = jfoe_pkg::RK_FINAL;
        final_res.ch       = 8'h00;
        final_res.last_run = 1'b1;
        if (over)
        begin
            final_res.st  = jfoe_pkg::ST_REQ_TOO_LARGE;
            final_res.len = 16'h0000;
        end
        else
        begin
            final_res.st  = (s2.lat == jfoe_pkg::ST_NONE) ? jfoe_pkg::ST_INVALID : s2.lat;
            final_res.len = 16'(s2.ccc);
        end

        emit_res.kind     = emit_kind;
        emit_res.ch       = emit_ch;
        emit_res.st       = 3'd0;
        emit_res.len      = 16'h0000;
        emit_res.last_run = !last_byte;

        res0    = final_res;
        res1    = final_res;
        res_cnt = 2'd0;
        if (emit_en)
        begin
            res0    = emit_res;
            res_cnt = last_byte ? 2'd2 : 2'd1;
        end
        else if (last_byte)
        begin
            res_cnt = 2'd1;
        end
    end

endmodule

/* rtl/jfoe_res_queue.sv */
module jfoe_res_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     wr_cnt,
    input  jfoe_pkg::res_t wr0,
    input  jfoe_pkg::res_t wr1,
    input  logic           rd_en,
    output jfoe_pkg::res_t rd_data,
    output logic           rd_valid,
    output logic           room
);

    jfoe_pkg::res_t                  mem_reg [jfoe_pkg::RQ_DEPTH];
    logic [jfoe_pkg::RQ_PTR_W-1:0]   wr_ptr_reg;
    logic [jfoe_pkg::RQ_PTR_W-1:0]   wr_ptr_next;
    logic [jfoe_pkg::RQ_PTR_W-1:0]   rd_ptr_reg;
    logic [jfoe_pkg::RQ_PTR_W-1:0]   rd_ptr_next;
    logic [jfoe_pkg::RQ_CNT_W-1:0]   cnt_reg;
    logic [jfoe_pkg::RQ_CNT_W-1:0]   cnt_next;
    logic [jfoe_pkg::RQ_PTR_W-1:0]   wr_ptr_1;

    assign wr_ptr_1 = wr_ptr_reg + jfoe_pkg::RQ_PTR_W'(1);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign rd_valid = cnt_reg != '0;
    assign room     = cnt_reg <= jfoe_pkg::RQ_CNT_W'(jfoe_pkg::RQ_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + jfoe_pkg::RQ_PTR_W'(wr_cnt);
        rd_ptr_next = rd_en ? rd_ptr_reg + jfoe_pkg::RQ_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + jfoe_pkg::RQ_CNT_W'(wr_cnt)
                    - jfoe_pkg::RQ_CNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jfoe_pkg::*;

    typedef struct {
        bit [7:0] data;
        bit       last;
        int       gap;
        bit       quiet;
    } byte_item_t;

    logic clk;
    logic rst_n;

    jfoe_in_if  in_if ();
    jfoe_out_if out_if ();

    json_flat_object_field_extractor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_if),
        .out_word (out_if)
    );

    // parser state mirror
    logic [4:0] ph;
    int         kmp;
    int         kcc;
    int         ehc;
    int         litp;
    bit         found;
    int         ccc;
    int         nreq;
    status_t    lat;
    bit         ended;

    res_t       run_words[$];
    res_t       expected_words[$];

    bit [7:0]   request_text[$];
    byte_item_t pending_bytes[$];
    byte_item_t next_item;

    int         bytes_total;
    int         bytes_taken;
    int         words_seen;
    int         errors;
    int         gap_done;
    int         stall_left;
    bit         tx_steady;
    bit         rx_steady;
    bit         rx_quiet;

    function automatic bit ws_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic bit dec_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_hexdig(logic [7:0] c);
        return dec_char(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic void reset_parser();
        ph    = P_BEFORE_OPEN;
        kmp   = 0;
        kcc   = 0;
        ehc   = 0;
        litp  = 0;
        found = 1'b0;
        ccc   = 0;
        nreq  = 0;
        lat   = ST_NONE;
        ended = 1'b0;
    endfunction

    function automatic void add_word(kind_t kind, logic [7:0] ch, logic [2:0] st, int len);
        res_t w;
        if (run_words.size() >= 2)
            return;
        w.kind     = kind;
        w.ch       = ch;
        w.st       = st;
        w.len      = 16'(len);
        w.last_run = 1'b0;
        run_words.push_back(w);
    endfunction

    function automatic void fail(status_t st);
        if (lat != ST_NONE)
            return;
        if (ph >= P_CODE && ph <= P_CODE_HEX)
            ccc = 0;
        lat = st;
    endfunction

    function automatic void str_char(logic [4:0] base, logic [7:0] c);
        string code_key;
        code_key = "code";
        if (base == P_KEY)
        begin
            if (kcc + 1 >= KEY_CAP)
            begin
                fail(ST_TOO_LARGE);
                return;
            end
            kcc++;
            if (kmp < MATCH_DONE)
                kmp = (c == code_key[kmp]) ? kmp + 1 : int'(MATCH_FAIL);
        end
        else if (base == P_CODE)
        begin
            if (ccc + 1 >= MAX_CODE)
            begin
                fail(ST_TOO_LARGE);
                return;
            end
            ccc++;
            add_word(RK_CHAR, c, ST_OK, 0);
        end
        ph = base;
    endfunction

    function automatic void str_byte(logic [4:0] base, logic [7:0] c);
        int sub;
        sub = int'(ph) - int'(base);
        if (sub == 0)
        begin
            if (c == CH_QUOTE)
            begin
                if (base == P_KEY)
                    ph = P_COLON;
                else
                begin
                    if (base == P_CODE)
                        found = 1'b1;
                    ph = P_AFTER_VALUE;
                end
            end
            else if (c < 8'd32)
                fail(ST_INVALID);
            else if (c == CH_BSLASH)
                ph = base + 5'd1;
            else
                str_char(base, c);
        end
        else if (sub == 1)
        begin
            case (c)
                CH_QUOTE, CH_BSLASH, CH_SLASH: str_char(base, c);
                CH_LO_B: str_char(base, CH_BS);
                CH_LO_F: str_char(base, CH_FF);
                CH_LO_N: str_char(base, CH_LF);
                CH_LO_R: str_char(base, CH_CR);
                CH_LO_T: str_char(base, CH_TAB);
                CH_LO_U:
                begin
                    ehc = 0;
                    ph  = base + 5'd2;
                end
                default: fail(ST_INVALID);
            endcase
        end
        else
        begin
            if (!is_hexdig(c))
            begin
                fail(ST_INVALID);
                return;
            end
            ehc++;
            if (ehc >= 4)
            begin
                ehc = 0;
                str_char(base, CH_QMARK);
            end
        end
    endfunction

    function automatic void after_value(logic [7:0] c);
        if (ws_char(c))
            return;
        if (c == CH_RBRACE)
            ph = P_AFTER_CLOSE;
        else if (c == CH_COMMA)
            ph = P_KEY_START;
        else
            fail(ST_INVALID);
    endfunction

    function automatic void close_number(logic [7:0] c);
        ph = P_AFTER_VALUE;
        after_value(c);
    endfunction

    function automatic void end_text();
        if (ph == P_AFTER_CLOSE)
            fail(found ? ST_OK : ST_MISSING);
        else
            fail(ST_INVALID);
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        logic [4:0] p;
        string      lit_word;
        bit         is_exp;
        p = ph;
        is_exp = (c == CH_LO_E || c == CH_UP_E);
        if (p == P_BEFORE_OPEN)
        begin
            if (c == CH_LBRACE)
                ph = P_AFTER_OPEN;
            else if (!ws_char(c))
                fail(ST_INVALID);
        end
        else if (p == P_AFTER_OPEN || p == P_KEY_START)
        begin
            if (ws_char(c))
                return;
            if (c == CH_QUOTE)
            begin
                kmp = 0;
                kcc = 0;
                ph  = P_KEY;
            end
            else if (c == CH_RBRACE && p == P_AFTER_OPEN)
                ph = P_AFTER_CLOSE;
            else
                fail(ST_INVALID);
        end
        else if (p >= P_KEY && p <= P_KEY_HEX)
            str_byte(P_KEY, c);
        else if (p == P_COLON)
        begin
            if (c == CH_COLON)
                ph = P_VALUE_START;
            else if (!ws_char(c))
                fail(ST_INVALID);
        end
        else if (p == P_VALUE_START)
        begin
            if (ws_char(c))
                return;
            if (kmp == MATCH_DONE)
            begin
                if (c == CH_QUOTE)
                begin
                    ccc = 0;
                    ph  = P_CODE;
                    add_word(RK_RESTART, 8'h00, ST_OK, 0);
                end
                else if (c == CH_COMMA || c == CH_RBRACE)
                    fail(ST_INVALID);
                else
                    fail(ST_NOT_STRING);
            end
            else if (c == CH_QUOTE)
                ph = P_SKIP;
            else if (c == CH_MINUS)
                ph = P_NUM_MINUS;
            else if (c == CH_ZERO)
                ph = P_NUM_ZERO;
            else if (dec_char(c))
                ph = P_NUM_INT;
            else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N)
            begin
                if (c == CH_LO_T)
                    ph = P_LIT_TRUE;
                else if (c == CH_LO_F)
                    ph = P_LIT_FALSE;
                else
                    ph = P_LIT_NULL;
                litp = 1;
            end
            else
                fail(ST_INVALID);
        end
        else if (p >= P_CODE && p <= P_CODE_HEX)
            str_byte(P_CODE, c);
        else if (p >= P_SKIP && p <= P_SKIP_HEX)
            str_byte(P_SKIP, c);
        else if (p >= P_NUM_MINUS && p <= P_NUM_EXP_DIG)
        begin
            case (p)
                P_NUM_MINUS:
                begin
                    if (c == CH_ZERO)
                        ph = P_NUM_ZERO;
                    else if (dec_char(c))
                        ph = P_NUM_INT;
                    else
                        fail(ST_INVALID);
                end
                P_NUM_ZERO, P_NUM_INT:
                begin
                    if (!(p == P_NUM_INT && dec_char(c)))
                    begin
                        if (c == CH_DOT)
                            ph = P_NUM_DOT;
                        else if (is_exp)
                            ph = P_NUM_EXP;
                        else
                            close_number(c);
                    end
                end
                P_NUM_DOT:
                begin
                    if (dec_char(c))
                        ph = P_NUM_FRAC;
                    else
                        fail(ST_INVALID);
                end
                P_NUM_FRAC:
                begin
                    if (!dec_char(c))
                    begin
                        if (is_exp)
                            ph = P_NUM_EXP;
                        else
                            close_number(c);
                    end
                end
                P_NUM_EXP:
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                        ph = P_NUM_EXP_SIGN;
                    else if (dec_char(c))
                        ph = P_NUM_EXP_DIG;
                    else
                        fail(ST_INVALID);
                end
                P_NUM_EXP_SIGN:
                begin
                    if (dec_char(c))
                        ph = P_NUM_EXP_DIG;
                    else
                        fail(ST_INVALID);
                end
                default:
                begin
                    if (!dec_char(c))
                        close_number(c);
                end
            endcase
        end
        else if (p >= P_LIT_TRUE && p <= P_LIT_NULL)
        begin
            if (p == P_LIT_TRUE)
                lit_word = "true";
            else if (p == P_LIT_FALSE)
                lit_word = "false";
            else
                lit_word = "null";
            if (litp >= lit_word.len() || c != lit_word[litp])
                fail(ST_INVALID);
            else
            begin
                litp++;
                if (litp >= lit_word.len())
                begin
                    litp = 0;
                    ph   = P_AFTER_VALUE;
                end
            end
        end
        else if (p == P_AFTER_VALUE)
            after_value(c);
        else if (p == P_AFTER_CLOSE)
        begin
            if (!ws_char(c))
                fail(ST_INVALID);
        end
        else
            fail(ST_INVALID);
    endfunction

    function automatic void extract_byte(logic [7:0] c, logic last);
        run_words.delete();
        if (nreq <= MAX_REQUEST)
            nreq++;
        if (nreq <= MAX_REQUEST && !ended)
        begin
            if (c == 8'h00)
            begin
                ended = 1'b1;
                if (lat == ST_NONE)
                    end_text();
            end
            else if (lat == ST_NONE)
                parse_byte(c);
        end
        if (last)
        begin
            if (!ended && lat == ST_NONE)
                end_text();
            if (nreq > MAX_REQUEST)
                add_word(RK_FINAL, 8'h00, ST_REQ_TOO_LARGE, 0);
            else
                add_word(RK_FINAL, 8'h00, (lat == ST_NONE) ? ST_INVALID : lat, ccc);
            reset_parser();
        end
        if (run_words.size() > 0)
            run_words[run_words.size() - 1].last_run = 1'b1;
        foreach (run_words[i])
            expected_words.push_back(run_words[i]);
    endfunction

    // request text builders
    function automatic void put_str(string s);
        int k;
        for (k = 0; k < s.len(); k++)
            request_text.push_back(s[k]);
    endfunction

    function automatic void put_ws();
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: request_text.push_back(CH_SPACE);
                1: request_text.push_back(CH_LF);
                2: request_text.push_back(CH_CR);
                default: request_text.push_back(CH_TAB);
            endcase
        end
    endfunction

    function automatic void put_text_char();
        string hex_digits;
        int    r;
        logic [7:0] c;
        hex_digits = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 19);
        if (r < 12)
        begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_QUOTE || c == CH_BSLASH)
                c = CH_LO_A;
            request_text.push_back(c);
        end
        else if (r < 14)
            request_text.push_back(8'($urandom_range(128, 255)));
        else
        begin
            request_text.push_back(CH_BSLASH);
            case ($urandom_range(0, 8))
                0: request_text.push_back(CH_QUOTE);
                1: request_text.push_back(CH_BSLASH);
                2: request_text.push_back(CH_SLASH);
                3: request_text.push_back(CH_LO_B);
                4: request_text.push_back(CH_LO_F);
                5: request_text.push_back(CH_LO_N);
                6: request_text.push_back(CH_LO_R);
                7: request_text.push_back(CH_LO_T);
                default:
                begin
                    request_text.push_back(CH_LO_U);
                    repeat (4)
                        request_text.push_back(hex_digits[$urandom_range(0, 21)]);
                end
            endcase
        end
    endfunction

    function automatic void put_string(int n);
        request_text.push_back(CH_QUOTE);
        repeat (n)
            put_text_char();
        request_text.push_back(CH_QUOTE);
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 1) == 1)
            request_text.push_back(CH_MINUS);
        if ($urandom_range(0, 2) == 0)
            request_text.push_back(CH_ZERO);
        else
        begin
            request_text.push_back(8'($urandom_range(8'h31, 8'h39)));
            repeat ($urandom_range(0, 3))
                request_text.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            request_text.push_back(CH_DOT);
            repeat ($urandom_range(1, 3))
                request_text.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            request_text.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
            case ($urandom_range(0, 2))
                0: request_text.push_back(CH_PLUS);
                1: request_text.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 3))
                request_text.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
    endfunction

    function automatic void put_value();
        case ($urandom_range(0, 5))
            0, 1: put_string($urandom_range(0, 6));
            2, 3: put_number();
            4: put_str($urandom_range(0, 1) ? "true" : "null");
            default: put_str("false");
        endcase
    endfunction

    function automatic bit put_key();
        bit code_key;
        code_key = 1'b0;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                put_str("\"code\"");
                code_key = 1'b1;
            end
            2:
            begin
                put_str("\"code");
                repeat ($urandom_range(1, 4))
                    put_text_char();
                request_text.push_back(CH_QUOTE);
                code_key = 1'b1;
            end
            3:
            begin
                case ($urandom_range(0, 2))
                    0: put_str("\"cod\"");
                    1: put_str("\"xcode\"");
                    default: put_str("\"Code\"");
                endcase
            end
            4: put_string($urandom_range(0, 5));
            default:
            begin
                request_text.push_back(CH_QUOTE);
                repeat ($urandom_range(29, 33))
                    request_text.push_back(8'($urandom_range(8'h61, 8'h7A)));
                request_text.push_back(CH_QUOTE);
            end
        endcase
        return code_key;
    endfunction

    function automatic void put_object();
        int n;
        int i;
        put_ws();
        request_text.push_back(CH_LBRACE);
        put_ws();
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                request_text.push_back(CH_COMMA);
                put_ws();
            end
            if (put_key())
            begin
                put_ws();
                request_text.push_back(CH_COLON);
                put_ws();
                if ($urandom_range(0, 9) == 0)
                    put_value();
                else
                    put_string($urandom_range(0, 12));
            end
            else
            begin
                put_ws();
                request_text.push_back(CH_COLON);
                put_ws();
                put_value();
            end
            put_ws();
        end
        request_text.push_back(CH_RBRACE);
        case ($urandom_range(0, 5))
            0:
            begin
                request_text.push_back(8'h00);
                repeat ($urandom_range(0, 3))
                    request_text.push_back(8'($urandom_range(0, 255)));
            end
            1: put_ws();
            default: ;
        endcase
    endfunction

    function automatic void send_request(bit quiet_run);
        byte_item_t it;
        int i;
        tx_steady = ($urandom_range(0, 3) == 0);
        for (i = 0; i < request_text.size(); i++)
        begin
            it.data  = request_text[i];
            it.last  = (i == request_text.size() - 1);
            it.gap   = (quiet_run || tx_steady) ? 0 : $urandom_range(0, 4);
            it.quiet = quiet_run;
            pending_bytes.push_back(it);
        end
        bytes_total += request_text.size();
        request_text.delete();
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // request byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= 8'h00;
            in_if.last_byte <= 1'b0;
            rx_quiet        <= 1'b0;
            gap_done = 0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                extract_byte(in_if.data_byte, in_if.last_byte);
                bytes_taken++;
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (pending_bytes.size() == 0)
                    in_if.valid <= 1'b0;
                else if (gap_done < pending_bytes[0].gap)
                begin
                    gap_done++;
                    in_if.valid <= 1'b0;
                end
                else
                begin
                    next_item = pending_bytes.pop_front();
                    gap_done  = 0;
                    in_if.valid     <= 1'b1;
                    in_if.data_byte <= next_item.data;
                    in_if.last_byte <= next_item.last;
                    rx_quiet        <= next_item.quiet;
                end
            end
        end
    end

    // result word monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (errors < 20)
                        $display("%0t: unexpected word kind=%0d char=%02h status=%0d len=%0d last=%0d",
                                 $time, out_if.result_kind, out_if.char_byte, out_if.status,
                                 out_if.value_length, out_if.last_of_run);
                    errors++;
                end
                else if (expected_words[0].kind !== out_if.result_kind
                         || expected_words[0].ch !== out_if.char_byte
                         || expected_words[0].st !== out_if.status
                         || expected_words[0].len !== out_if.value_length
                         || expected_words[0].last_run !== out_if.last_of_run)
                begin
                    if (errors < 20)
                    begin
                        $display("%0t: expected kind=%0d char=%02h status=%0d len=%0d last=%0d",
                                 $time, expected_words[0].kind, expected_words[0].ch,
                                 expected_words[0].st, expected_words[0].len,
                                 expected_words[0].last_run);
                        $display("%0t:   actual kind=%0d char=%02h status=%0d len=%0d last=%0d",
                                 $time, out_if.result_kind, out_if.char_byte, out_if.status,
                                 out_if.value_length, out_if.last_of_run);
                    end
                    errors++;
                end
                if (expected_words.size() > 0)
                    expected_words.delete(0);
                words_seen++;
                // long hold so the result queue fills and input backs up
                if (words_seen == 250 || words_seen == 20000)
                    stall_left = 300;
                else if (rx_quiet || rx_steady)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 4);
                if ($urandom_range(0, 63) == 0)
                    rx_steady = !rx_steady;
            end
            else if (stall_left > 0)
                stall_left--;
            out_if.ready <= (stall_left == 0);
        end
    end

    initial
    begin
        int random_bytes;
        int idx;
        int i;
        string punct;

        punct           = "{}[]:,\"0";
        random_bytes    = 0;
        bytes_total     = 0;
        bytes_taken     = 0;
        words_seen      = 0;
        errors          = 0;
        rx_steady       = 1'b0;
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        reset_parser();

        // directed requests
        put_str("{\"code\":\"abc\"}");
        send_request(1'b0);
        put_str("{}");
        send_request(1'b0);
        put_str("\n{ \t}\r ");
        send_request(1'b0);
        put_str("{\"a\":1,\"b\":-0.5e+3,\"c\":true,\"d\":false,\"e\":null,\"f\":0E-1,");
        put_str("\"code\":\"q\\\"\\\\\\/\\b\\f\\n\\r\\t\\u00aF\"}");
        send_request(1'b0);
        put_str("{\"code\":5}");
        send_request(1'b0);
        put_str("{\"code\":}");
        send_request(1'b0);
        put_str("{\"a\":{}}");
        send_request(1'b0);
        put_str("{\"");
        for (i = 0; i < KEY_CAP - 1; i++)
            request_text.push_back(CH_LO_C);
        put_str("\":0,\"code\":\"k\"}");
        send_request(1'b0);
        put_str("{\"");
        repeat (KEY_CAP)
            request_text.push_back(CH_LO_C);
        put_str("\":0}");
        send_request(1'b0);
        put_str("{\"code\":\"a");
        request_text.push_back(8'h01);
        put_str("\"}");
        send_request(1'b0);
        put_str("{\"code\":\"z\"}");
        request_text.push_back(8'h00);
        put_str("x]");
        send_request(1'b0);
        put_str("{\"co");
        request_text.push_back(8'h00);
        put_str("de\":1}");
        send_request(1'b0);
        put_str("{\"code\":\"ab\",\"codex\":\"c\"}");
        send_request(1'b0);
        put_str("{\"code\":\"ab");
        send_request(1'b0);
        put_str("{\"k\":\"\\q\",\"n\":01}");
        send_request(1'b0);
        put_str("{\"n\":1.}");
        send_request(1'b0);
        put_str("{\"n\":1e}");
        send_request(1'b0);
        put_str("{\"a\":nulL}");
        send_request(1'b0);
        put_str("{\"code\":\"a\"}x");
        send_request(1'b0);
        put_str("{");
        send_request(1'b0);
        request_text.push_back(8'h00);
        send_request(1'b0);
        put_str("{\"code\":\"\\u12G4\"}");
        send_request(1'b0);
        put_str("{\"xcode\":\"v\",\"code_2\":\"\"}");
        send_request(1'b0);
        put_str("{\"code\":\"");
        request_text.push_back(8'hFF);
        request_text.push_back(8'h80);
        put_str("\",}");
        send_request(1'b0);

        // random requests, mostly well formed
        while (random_bytes < 1525)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: put_object();
                7, 8:
                begin
                    put_object();
                    idx = $urandom_range(0, request_text.size() - 1);
                    case ($urandom_range(0, 2))
                        0: request_text[idx] = 8'($urandom_range(0, 255));
                        1: request_text = request_text[0:idx];
                        default: request_text.insert(idx, punct[$urandom_range(0, 7)]);
                    endcase
                end
                default:
                begin
                    repeat ($urandom_range(1, 8))
                        request_text.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            random_bytes += request_text.size();
            send_request(1'b0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != bytes_total)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
